// ----- sv/tmq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tmq_pkg;

  localparam int CAPACITY = 32;

  localparam int CMD_W = 3;
  localparam int ST_W  = 2;
  localparam int CNT_W = 6;
  localparam int KEY_W = 18;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD          = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_ORDERED  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_ANY      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH_RANGE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH_SENDER = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COUNT_TURN   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_EXPECTED_SEQ = 3'd6;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  localparam logic [KEY_W-1:0] KEY_SCALE = 18'd1000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [31:0]      turn;
    logic [31:0]      last_turn;
    logic [7:0]       sender;
    logic [7:0]       seq_in;
    logic [15:0]      payload_tag;
    logic [15:0]      payload_len;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [15:0]      tag_out;
    logic [15:0]      len_out;
    logic [CNT_W-1:0] count;
    logic [7:0]       seq_out;
  } out_item_t;

  typedef struct packed {
    logic [31:0] turn;
    logic [7:0]  sender;
    logic [7:0]  seq;
    logic [15:0] tag;
    logic [15:0] len;
  } slot_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/tmq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tmq_pkg::dp_cmd_t       dp_cmd,
  input  wire tmq_pkg::dp_stat_t dp_stat
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (dp_stat.scan_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign dp_cmd.load   = (state_r == S_IDLE) && in_valid;
  assign dp_cmd.scan   = (state_r == S_SCAN);
  assign dp_cmd.finish = (state_r == S_FINISH);

endmodule

`default_nettype wire

// ----- sv/tmq_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmq_dpath #(
  parameter int CAPACITY = tmq_pkg::CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tmq_pkg::dp_cmd_t  dp_cmd,
  output tmq_pkg::dp_stat_t      dp_stat,
  input  wire tmq_pkg::in_item_t in_data,
  output tmq_pkg::out_item_t     out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW:0] LAST_SLOT = (IW + 1)'(CAPACITY - 1);
  localparam int CW = tmq_pkg::CNT_W;
  localparam int KW = tmq_pkg::KEY_W;

  tmq_pkg::slot_t mem [CAPACITY];

  tmq_pkg::in_item_t  item_r;
  logic [CAPACITY-1:0] valid_r;
  logic [IW-1:0]       high_mark_r;

  logic [IW:0]         rd_idx_r;
  logic                proc_v_r;
  logic [IW-1:0]       proc_idx_r;
  tmq_pkg::slot_t      rd_data_r;
  logic                rd_vld_r;

  logic                stop_r;
  logic                found_r;
  logic [IW-1:0]       pick_r;
  logic [KW-1:0]       best_key_r;
  logic [15:0]         best_tag_r;
  logic [15:0]         best_len_r;
  logic [CW-1:0]       count_r;
  logic [7:0]          seq_r;
  tmq_pkg::out_item_t  out_r;

  logic [IW:0]         limit;
  logic                rd_live;
  tmq_pkg::slot_t      eff;
  logic                occ;
  logic [KW-1:0]       key;
  logic                turn_eq;
  logic                sender_eq;
  logic                in_range;
  logic                proc_en;
  logic [CW-1:0]       count_inc;
  tmq_pkg::out_item_t  res;

  assign limit   = (item_r.cmd == tmq_pkg::CMD_ADD) ? LAST_SLOT : {1'b0, high_mark_r};
  assign rd_live = dp_cmd.scan && !stop_r && (rd_idx_r <= limit);
  assign dp_stat.scan_done = dp_cmd.scan && !proc_v_r && (stop_r || (rd_idx_r > limit));

  // a slot whose valid bit is off reads as all zero
  assign eff       = rd_vld_r ? rd_data_r : '0;
  assign occ       = (eff.len != 16'd0);
  assign key       = KW'(eff.seq) + KW'(eff.sender) * tmq_pkg::KEY_SCALE;
  assign turn_eq   = (eff.turn == item_r.turn);
  assign sender_eq = (eff.sender == item_r.sender);
  assign in_range  = ((item_r.turn == 32'd0) && (item_r.last_turn == 32'd0)) ||
                     ((item_r.turn <= eff.turn) && (eff.turn <= item_r.last_turn));
  assign proc_en   = dp_cmd.scan && proc_v_r && !stop_r;
  assign count_inc = (count_r == {CW{1'b1}}) ? count_r : count_r + CW'(1);

  // slot table
  always_ff @(posedge clk) begin
    if (dp_cmd.finish && (item_r.cmd == tmq_pkg::CMD_ADD) && found_r) begin
      mem[pick_r] <= '{turn:   item_r.turn,
                       sender: item_r.sender,
                       seq:    item_r.seq_in,
                       tag:    item_r.payload_tag,
                       len:    item_r.payload_len};
    end
    if (rd_live) begin
      rd_data_r <= mem[rd_idx_r[IW-1:0]];
    end
  end

  // read stage and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      high_mark_r <= '0;
      proc_v_r    <= 1'b0;
    end else begin
      proc_v_r <= rd_live;
      if (proc_en && occ) begin
        case (item_r.cmd)
          tmq_pkg::CMD_POP_ANY:      valid_r[proc_idx_r] <= 1'b0;
          tmq_pkg::CMD_FLUSH_RANGE:  if (in_range) valid_r[proc_idx_r] <= 1'b0;
          tmq_pkg::CMD_FLUSH_SENDER: if (sender_eq) valid_r[proc_idx_r] <= 1'b0;
          default: ;
        endcase
      end
      if (dp_cmd.finish && found_r) begin
        case (item_r.cmd)
          tmq_pkg::CMD_ADD: begin
            valid_r[pick_r] <= 1'b1;
            if (pick_r > high_mark_r) high_mark_r <= pick_r;
          end
          tmq_pkg::CMD_POP_ORDERED: valid_r[pick_r] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_live) begin
      rd_vld_r   <= valid_r[rd_idx_r[IW-1:0]];
      proc_idx_r <= rd_idx_r[IW-1:0];
      rd_idx_r   <= rd_idx_r + (IW + 1)'(1);
    end
    if (dp_cmd.load) begin
      item_r   <= in_data;
      rd_idx_r <= '0;
      stop_r   <= 1'b0;
      found_r  <= 1'b0;
      count_r  <= '0;
      seq_r    <= 8'd1;
      best_tag_r <= '0;
      best_len_r <= '0;
      best_key_r <= '0;
      pick_r     <= '0;
    end else if (proc_en) begin
      case (item_r.cmd)
        tmq_pkg::CMD_ADD: begin
          if (!occ) begin
            stop_r  <= 1'b1;
            found_r <= 1'b1;
            pick_r  <= proc_idx_r;
          end
        end
        tmq_pkg::CMD_POP_ORDERED: begin
          // strict compare keeps the lowest index on equal keys
          if ((key != '0) && occ && turn_eq && (!found_r || (key < best_key_r))) begin
            found_r    <= 1'b1;
            pick_r     <= proc_idx_r;
            best_key_r <= key;
            best_tag_r <= eff.tag;
            best_len_r <= eff.len;
          end
        end
        tmq_pkg::CMD_POP_ANY: begin
          if (occ) begin
            stop_r     <= 1'b1;
            found_r    <= 1'b1;
            best_tag_r <= eff.tag;
            best_len_r <= eff.len;
          end
        end
        tmq_pkg::CMD_FLUSH_RANGE: begin
          if (in_range) count_r <= count_inc;
        end
        tmq_pkg::CMD_COUNT_TURN: begin
          if (turn_eq) count_r <= count_inc;
        end
        tmq_pkg::CMD_EXPECTED_SEQ: begin
          if (turn_eq && sender_eq && occ) seq_r <= seq_r + 8'd1;
        end
        default: ;
      endcase
    end
    if (dp_cmd.finish) begin
      out_r <= res;
    end
  end

  always_comb begin
    res = '0;
    res.status = tmq_pkg::ST_OK;
    case (item_r.cmd)
      tmq_pkg::CMD_ADD: begin
        if (!found_r) res.status = tmq_pkg::ST_FULL;
      end
      tmq_pkg::CMD_POP_ORDERED, tmq_pkg::CMD_POP_ANY: begin
        if (found_r) begin
          res.tag_out = best_tag_r;
          res.len_out = best_len_r;
        end else begin
          res.status = tmq_pkg::ST_NOT_FOUND;
        end
      end
      tmq_pkg::CMD_FLUSH_RANGE, tmq_pkg::CMD_COUNT_TURN: begin
        res.count = count_r;
      end
      tmq_pkg::CMD_EXPECTED_SEQ: begin
        res.seq_out = seq_r;
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ----- sv/turn_tagged_message_queue_unit.sv -----
// Turn-tagged message queue over a table of CAPACITY slots.
// Input channel (in_valid / in_ready / in_data) takes one command item; the
// result channel (out_valid / out_ready / out_data) returns exactly one
// result item for it. One command is in flight at a time: in_ready is high
// only while the unit is idle.
// Each command is accepted, then scanned one slot per cycle through the slot
// memory's registered read port (slots 0 up to the high-water mark, or the
// whole table for an add, ending early once an add or a pop-any finds its
// slot); the unit then sees the scan end, commits in a finish state and
// presents the result. The next item is taken the cycle after the result
// is accepted.
// Reset (rst_n low at a clock edge) clears every slot's valid bit, so the
// whole table reads as zero and free at once, and zeroes the high-water
// mark; no clearing pass is needed.
// A stalled receiver holds out_valid and out_data steady; no new item is
// taken until the result leaves.
`timescale 1ns / 1ps
`default_nettype none

module turn_tagged_message_queue_unit #(
  parameter int CAPACITY = tmq_pkg::CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tmq_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tmq_pkg::out_item_t     out_data
);

  tmq_pkg::dp_cmd_t  dp_cmd;
  tmq_pkg::dp_stat_t dp_stat;

  tmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  tmq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- sv/tmq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire tmq_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: never take an item while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // an accepted item goes to the scan: in_ready and out_valid are low in the cycle after the accept
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("result or ready right after accept");

  // result leaves, unit is idle again
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("unit not idle after result taken");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == tmq_pkg::ST_OK) ||
                  (out_data.status == tmq_pkg::ST_NOT_FOUND) ||
                  (out_data.status == tmq_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind turn_tagged_message_queue_unit tmq_checker u_tmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
